// ===== rtl/cct_pkg.sv =====
// Shared types, codes and constants of the character-class tokenizer.
// Used by the channel interfaces and every module of the block but cct_ram.
`timescale 1ns / 1ps

package cct_pkg;

  // Alphabet covered by the class table; bytes at or above it read as token.
  localparam int ALPHABET_SIZE = 256;
  localparam int CHAR_W        = 8;
  localparam int TBL_AW        = $clog2(ALPHABET_SIZE);
  localparam int CLASS_W       = 2;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] TAB_CHAR     = 8'd9;
  localparam logic [CHAR_W-1:0] CR_CHAR      = 8'd13;

  typedef enum logic [1:0] {
    FUNC_CHAR  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2
  } cct_func_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_TOKEN = 2'd0,
    CLS_WS    = 2'd1,
    CLS_PUNCT = 2'd2,
    CLS_QUOTE = 2'd3
  } cct_class_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2
  } cct_mode_e;

  // One result word.
  typedef struct packed {
    logic [CHAR_W-1:0] token_char;
    logic              has_char;
    logic              token_end;
    logic              was_quoted;
    logic              last;
  } cct_res_t;

  // Class table write command.
  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    cct_class_e        data;
  } cct_wr_t;

  function automatic logic char_in_range(input logic [CHAR_W-1:0] c);
    char_in_range = ({1'b0, c} < (CHAR_W+1)'(ALPHABET_SIZE));
  endfunction

  // Class of a byte before any write to its entry.
  function automatic cct_class_e reset_class(input logic [CHAR_W-1:0] c);
    if (((c >= TAB_CHAR) && (c <= CR_CHAR)) || (c == SPACE_CHAR)) begin
      reset_class = CLS_WS;
    end else begin
      reset_class = CLS_TOKEN;
    end
  endfunction

endpackage

// ===== rtl/cct_if.sv =====
// Valid/ready channel interfaces of the tokenizer: input words and result words.
// Depends on cct_pkg for field widths.
`timescale 1ns / 1ps

interface cct_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [cct_pkg::CHAR_W-1:0] char_code;
  logic                      end_of_stream;
  logic [1:0]                class_code;

  modport source (output valid, func, char_code, end_of_stream, class_code, input ready);
  modport sink   (input valid, func, char_code, end_of_stream, class_code, output ready);
endinterface

interface cct_out_if;
  logic                      valid;
  logic                      ready;
  logic [cct_pkg::CHAR_W-1:0] token_char;
  logic                      has_char;
  logic                      token_end;
  logic                      was_quoted;
  logic                      last;

  modport source (output valid, token_char, has_char, token_end, was_quoted, last,
                  input ready);
  modport sink   (input valid, token_char, has_char, token_end, was_quoted, last,
                  output ready);
endinterface

// ===== rtl/cct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cct_class_table.sv =====
// Byte class table: RAM plus per-entry valid bits that stand for the reset classes.
// Depends on cct_pkg and cct_ram.
`timescale 1ns / 1ps

module cct_class_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [cct_pkg::CHAR_W-1:0] rd_char_i,
  input  cct_pkg::cct_wr_t           wr_i,
  output cct_pkg::cct_class_e        cls_o
);

  localparam int AW = cct_pkg::TBL_AW;

  logic [cct_pkg::ALPHABET_SIZE-1:0] vld_q;
  logic [AW-1:0]                     raddr;
  logic [cct_pkg::CLASS_W-1:0]       rdata;

  // Read-side side information, captured with the RAM read
  logic                vld_rd_q;
  cct_pkg::cct_class_e rst_cls_q;
  logic                out_rng_q;
  logic                byp_q;
  cct_pkg::cct_class_e byp_data_q;

  assign raddr = rd_char_i[AW-1:0];

  cct_ram #(
    .WIDTH (cct_pkg::CLASS_W),
    .DEPTH (cct_pkg::ALPHABET_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (rd_en_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Capture valid bit, reset class, range flag and a same-edge write for forwarding
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      vld_rd_q   <= vld_q[raddr];
      rst_cls_q  <= cct_pkg::reset_class(rd_char_i);
      out_rng_q  <= !cct_pkg::char_in_range(rd_char_i);
      byp_q      <= wr_i.en && (wr_i.addr == raddr);
      byp_data_q <= wr_i.data;
    end
  end

  // Select the effective class
  always_comb begin
    if (out_rng_q) begin
      cls_o = cct_pkg::CLS_TOKEN;
    end else if (byp_q) begin
      cls_o = byp_data_q;
    end else if (vld_rd_q) begin
      cls_o = cct_pkg::cct_class_e'(rdata);
    end else begin
      cls_o = rst_cls_q;
    end
  end

endmodule

// ===== rtl/cct_scan.sv =====
// Scanner step: scan mode and open quote, result words and class table writes.
// Depends on cct_pkg.
`timescale 1ns / 1ps

module cct_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [1:0]                 func_i,
  input  logic [cct_pkg::CHAR_W-1:0] char_i,
  input  logic                       eos_i,
  input  cct_pkg::cct_class_e        cls_arg_i,
  input  cct_pkg::cct_class_e        tbl_cls_i,
  output cct_pkg::cct_wr_t           wr_o,
  output cct_pkg::cct_res_t [1:0]    res_o,
  output logic [1:0]                 res_cnt_o
);

  cct_pkg::cct_mode_e        mode_q, mode_d;
  logic [cct_pkg::CHAR_W-1:0] quote_q, quote_d;

  logic              pre_vld;
  cct_pkg::cct_res_t pre_res;
  logic              body_vld;
  cct_pkg::cct_res_t body_res;
  logic              run_idle;
  logic              in_rng;

  assign in_rng = cct_pkg::char_in_range(char_i);

  // Work out the results and the next scan state
  always_comb begin
    mode_d   = mode_q;
    quote_d  = quote_q;
    pre_vld  = 1'b0;
    pre_res  = '0;
    body_vld = 1'b0;
    body_res = '0;
    run_idle = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.addr = char_i[cct_pkg::TBL_AW-1:0];
    wr_o.data = cls_arg_i;

    pre_res.token_end = 1'b1;

    unique case (func_i)
      cct_pkg::FUNC_CHAR: begin
        if (eos_i) begin
          // close an open token
          pre_vld            = (mode_q == cct_pkg::MODE_PLAIN) ||
                               (mode_q == cct_pkg::MODE_QUOTED);
          pre_res.was_quoted = (mode_q == cct_pkg::MODE_QUOTED);
          mode_d             = cct_pkg::MODE_IDLE;
        end else begin
          unique case (mode_q)
            cct_pkg::MODE_PLAIN: begin
              if (tbl_cls_i == cct_pkg::CLS_TOKEN) begin
                body_vld            = 1'b1;
                body_res.token_char = char_i;
                body_res.has_char   = 1'b1;
              end else begin
                pre_vld  = 1'b1;
                mode_d   = cct_pkg::MODE_IDLE;
                run_idle = 1'b1;
              end
            end
            cct_pkg::MODE_QUOTED: begin
              if (char_i == quote_q) begin
                pre_vld            = 1'b1;
                pre_res.was_quoted = 1'b1;
                mode_d             = cct_pkg::MODE_IDLE;
              end else if (char_i == cct_pkg::NEWLINE_CHAR) begin
                pre_vld            = 1'b1;
                pre_res.was_quoted = 1'b1;
                mode_d             = cct_pkg::MODE_IDLE;
                run_idle           = 1'b1;
              end else begin
                body_vld            = 1'b1;
                body_res.token_char = char_i;
                body_res.has_char   = 1'b1;
                body_res.was_quoted = 1'b1;
              end
            end
            default: begin
              mode_d   = cct_pkg::MODE_IDLE;
              run_idle = 1'b1;
            end
          endcase
        end
      end
      cct_pkg::FUNC_SET: begin
        wr_o.en = step_i && in_rng;
      end
      cct_pkg::FUNC_CLEAR: begin
        wr_o.en   = step_i && in_rng && (tbl_cls_i == cls_arg_i);
        wr_o.data = cct_pkg::CLS_TOKEN;
      end
      default: ;
    endcase

    // Handle the byte as seen between tokens
    if (run_idle) begin
      unique case (tbl_cls_i)
        cct_pkg::CLS_WS: ;
        cct_pkg::CLS_PUNCT: begin
          body_vld            = 1'b1;
          body_res.token_char = char_i;
          body_res.has_char   = 1'b1;
          body_res.token_end  = 1'b1;
        end
        cct_pkg::CLS_QUOTE: begin
          quote_d = char_i;
          mode_d  = cct_pkg::MODE_QUOTED;
        end
        default: begin
          body_vld            = 1'b1;
          body_res.token_char = char_i;
          body_res.has_char   = 1'b1;
          mode_d              = cct_pkg::MODE_PLAIN;
        end
      endcase
    end
  end

  // Pack the results and mark the last one
  always_comb begin
    res_cnt_o = {1'b0, pre_vld} + {1'b0, body_vld};
    res_o[0]  = pre_vld ? pre_res : body_res;
    res_o[1]  = body_res;
    if (res_cnt_o == 2'd2) begin
      res_o[1].last = 1'b1;
    end else begin
      res_o[0].last = 1'b1;
    end
  end

  // Advance the scan state when the item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cct_pkg::MODE_IDLE;
      quote_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
    end
  end

  // Two results only come from closing an open token
  a_two_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res_cnt_o == 2'd2)) |->
      ((mode_q == cct_pkg::MODE_PLAIN) || (mode_q == cct_pkg::MODE_QUOTED)))
    else $error("two results without an open token");

endmodule

// ===== rtl/cct_out_buf.sv =====
// Two-entry result register that drives the output channel.
// Depends on cct_pkg and cct_out_if.
`timescale 1ns / 1ps

module cct_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  cct_pkg::cct_res_t [1:0] push_res_i,
  input  logic [1:0]              push_cnt_i,
  output logic                    free_o,
  cct_out_if.source               out_o
);

  cct_pkg::cct_res_t [1:0] slot_q;
  logic [1:0]              cnt_q;
  logic                    pop;

  assign pop    = (cnt_q != 2'd0) && out_o.ready;
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  // Count of held words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i) begin
      cnt_q <= push_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Load new words or advance the second to the head
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q <= push_res_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.token_char = slot_q[0].token_char;
  assign out_o.has_char   = slot_q[0].has_char;
  assign out_o.token_end  = slot_q[0].token_end;
  assign out_o.was_quoted = slot_q[0].was_quoted;
  assign out_o.last       = slot_q[0].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!slot_q[0].last && slot_q[1].last))
    else $error("last mark misplaced in a result pair");

  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q != 2'd0) && !slot_q[0].has_char) |-> slot_q[0].token_end)
    else $error("bare result that does not end a token");

endmodule

// ===== rtl/char_class_tokenizer_unit.sv =====
// Top level of the character-class tokenizer.
// Depends on cct_pkg, cct_if, cct_class_table, cct_scan and cct_out_buf.
//
// Usage:
//   in_i carries input words: a byte (func character), an end-of-stream mark,
//   or a write that sets or clears the class of one byte in the class table.
//   out_o carries result words: one token byte or a bare token end,
//   with token_end, was_quoted and last marks; last flags the final word that
//   an input word caused. Words that cause no result produce nothing.
// Timing: a word accepted at an edge is looked up in the class table at that
//   edge and held in the input stage; its results are loaded into the output
//   register once that register is free, and the first result is offered from it.
// Throughput: one input word per cycle while each word gives at most one
//   result and the receiver takes each result as offered; a word with two
//   results holds the output register until the output port has passed both on.
// Reset: the class table reads whitespace for bytes 9..13 and 32 and token for
//   all others (per-entry valid bits, no clearing pass), and the scanner is
//   between tokens. When the receiver stalls, results are held and input stops
//   once the input stage and output register are both full.
`timescale 1ns / 1ps

module char_class_tokenizer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cct_in_if.sink    in_i,
  cct_out_if.source out_o
);

  logic                       acc;
  logic                       adv;
  logic                       ob_free;

  logic                       s1_vld_q;
  logic [1:0]                 s1_func_q;
  logic [cct_pkg::CHAR_W-1:0] s1_char_q;
  logic                       s1_eos_q;
  cct_pkg::cct_class_e        s1_cls_q;

  cct_pkg::cct_class_e        tbl_cls;
  cct_pkg::cct_wr_t           wr;
  cct_pkg::cct_res_t [1:0]    res;
  logic [1:0]                 res_cnt;

  // Handshake: accept when the stage is empty or moves on this cycle
  assign adv        = s1_vld_q && ob_free;
  assign in_i.ready = !s1_vld_q || adv;
  assign acc        = in_i.valid && in_i.ready;

  // Input stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (acc) begin
      s1_vld_q <= 1'b1;
    end else if (adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_func_q <= in_i.func;
      s1_char_q <= in_i.char_code;
      s1_eos_q  <= in_i.end_of_stream;
      s1_cls_q  <= cct_pkg::cct_class_e'(in_i.class_code);
    end
  end

  cct_class_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_char_i (in_i.char_code),
    .wr_i      (wr),
    .cls_o     (tbl_cls)
  );

  cct_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .func_i    (s1_func_q),
    .char_i    (s1_char_q),
    .eos_i     (s1_eos_q),
    .cls_arg_i (s1_cls_q),
    .tbl_cls_i (tbl_cls),
    .wr_o      (wr),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  cct_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (adv),
    .push_res_i (res),
    .push_cnt_i (res_cnt),
    .free_o     (ob_free),
    .out_o      (out_o)
  );

endmodule
